[rtl/mml_pkg.sv]
// ----------------------------------------------------------------------------
// mml_pkg
// shared types, codes and defaults for the modulation matrix with lerp
// ----------------------------------------------------------------------------
package mml_pkg;

  localparam int NUM_CONTROLS_DEF      = 6;
  localparam int SLOTS_PER_CONTROL_DEF = 16;

  // request command codes
  localparam logic [2:0] CMD_SET    = 3'd0;
  localparam logic [2:0] CMD_ADD    = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_QUERY  = 3'd5;

  // routing target of one slot
  typedef struct packed {
    logic [3:0] chan;
    logic [7:0] key;
    logic [7:0] par;
  } meta_t;

  // interpolation end points, signed q8.8
  typedef struct packed {
    logic signed [15:0] start_val;
    logic signed [15:0] end_val;
  } vals_t;

  // write strobes into the slot table
  typedef struct packed {
    logic meta_we;
    logic vals_we;
  } tbl_we_t;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_READ   = 8'b0000_0100,
    S_LERP   = 8'b0000_1000,
    S_OUT    = 8'b0001_0000,
    S_CLR_RD = 8'b0010_0000,
    S_CLR_CK = 8'b0100_0000,
    S_QRY    = 8'b1000_0000
  } state_t;

endpackage

[rtl/mml_table.sv]
// ----------------------------------------------------------------------------
// mml_table
// slot entry storage: target and end-point memories, one write and one
// registered read per cycle
// ----------------------------------------------------------------------------
module mml_table
  import mml_pkg::*;
#(
  parameter int DEPTH = NUM_CONTROLS_DEF * SLOTS_PER_CONTROL_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  tbl_we_t       we,
  input  logic [AW-1:0] wr_addr,
  input  meta_t         wr_meta,
  input  vals_t         wr_vals,
  input  logic [AW-1:0] rd_addr,
  output meta_t         rd_meta,
  output vals_t         rd_vals
);

  meta_t meta_mem [DEPTH];
  vals_t vals_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we.meta_we) begin
      meta_mem[wr_addr] <= wr_meta;
    end
    if (we.vals_we) begin
      vals_mem[wr_addr] <= wr_vals;
    end
  end

  always_ff @(posedge clk) begin
    rd_meta <= meta_mem[rd_addr];
    rd_vals <= vals_mem[rd_addr];
  end

endmodule

[rtl/mml_lerp.sv]
// ----------------------------------------------------------------------------
// mml_lerp
// shared interpolation unit: start + round(val * (end - start)), two stages
// ----------------------------------------------------------------------------
module mml_lerp
  import mml_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  vals_t              vals,
  input  logic [15:0]        ctl_val,
  output logic               done,
  output logic signed [15:0] result
);

  logic signed [16:0] diff;
  logic signed [16:0] val_s;
  logic signed [33:0] prod;
  logic signed [15:0] start_r;
  logic               s1_v;
  logic signed [33:0] rnd;
  logic signed [17:0] q;
  logic signed [18:0] sum;

  assign diff  = 17'(vals.end_val) - 17'(vals.start_val);
  assign val_s = {1'b0, ctl_val};

  always_ff @(posedge clk) begin
    if (go) begin
      prod    <= diff * val_s;
      start_r <= vals.start_val;
    end
  end

  // round to nearest, ties up
  assign rnd = prod + 34'sd32768;
  assign q   = rnd[33:16];
  assign sum = 19'(start_r) + 19'(q);

  always_ff @(posedge clk) begin
    if (sum > 19'sd32767) begin
      result <= 16'sh7fff;
    end else if (sum < -19'sd32768) begin
      result <= -16'sh8000;
    end else begin
      result <= sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_v <= go;
      done <= s1_v;
    end
  end

endmodule

[rtl/modulation_matrix_lerp_top.sv]
// ----------------------------------------------------------------------------
// modulation_matrix_lerp_top
// routing table from controls to effect parameters with linear interpolation
// ----------------------------------------------------------------------------
// One request at a time. Add, update and remove are done in the accept
// cycle and return nothing. A set-value request walks the slots of its
// control one per cycle while it skips empty slots; each valid slot goes
// through a table read and the two-stage shared multiply/round unit, then
// waits for its result to be taken. A query checks one control per cycle,
// stopping at the first hit, then holds its single result. Clear channel
// sweeps the whole table through its one read port, with a read state and a
// check state per slot. Slot valid bits are cleared by reset itself.
// ----------------------------------------------------------------------------
module modulation_matrix_lerp_top
  import mml_pkg::*;
#(
  parameter int NUM_CONTROLS      = NUM_CONTROLS_DEF,
  parameter int SLOTS_PER_CONTROL = SLOTS_PER_CONTROL_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         cmd,
  input  logic [2:0]         control,
  input  logic [3:0]         slot,
  input  logic [3:0]         channel,
  input  logic [7:0]         fx_key,
  input  logic [7:0]         fx_param,
  input  logic signed [15:0] start_value,
  input  logic signed [15:0] end_value,
  input  logic [15:0]        control_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_channel,
  output logic [7:0]         out_fx_key,
  output logic [7:0]         out_fx_param,
  output logic signed [15:0] fx_value,
  output logic [2:0]         mod_state,
  output logic               last
);

  localparam int DEPTH = NUM_CONTROLS * SLOTS_PER_CONTROL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
  localparam int SW    = (SLOTS_PER_CONTROL > 1) ? $clog2(SLOTS_PER_CONTROL) : 1;
  localparam logic [CW-1:0] C_LAST = CW'(NUM_CONTROLS - 1);
  localparam logic [SW-1:0] S_LAST = SW'(SLOTS_PER_CONTROL - 1);
  localparam logic [2:0]    NONE   = 3'(NUM_CONTROLS);

  state_t state, state_next;

  logic [SLOTS_PER_CONTROL-1:0] slot_valid [NUM_CONTROLS];

  logic [CW-1:0] ctl_r;
  logic [SW-1:0] s_cnt;
  logic [SW-1:0] slot_r;
  logic          slot_ok_r;
  logic [3:0]    chan_r;
  logic [15:0]   val_r;

  logic          acc;
  logic          ctl_ok;
  logic          slot_ok;
  logic [CW-1:0] in_ci;
  logic [SW-1:0] in_si;
  logic          in_hit;
  logic          more;
  logic          q_hit;
  logic          clr_hit;

  tbl_we_t       we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  meta_t         wr_meta;
  vals_t         wr_vals;
  meta_t         rd_meta;
  vals_t         rd_vals;

  logic               lerp_go;
  logic               lerp_done;
  logic signed [15:0] lerp_res;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign acc       = in_valid && in_ready;

  assign ctl_ok  = int'(control) < NUM_CONTROLS;
  assign slot_ok = int'(slot) < SLOTS_PER_CONTROL;
  assign in_ci   = CW'(control);
  assign in_si   = SW'(slot);
  assign in_hit  = ctl_ok && slot_ok && slot_valid[in_ci][in_si];

  // table writes happen in the accept cycle
  assign we.meta_we = acc && (cmd == CMD_ADD) && ctl_ok && slot_ok;
  assign we.vals_we = we.meta_we || (acc && (cmd == CMD_UPDATE) && in_hit);
  assign wr_addr    = AW'(int'(in_ci) * SLOTS_PER_CONTROL + int'(in_si));
  assign wr_meta    = '{chan: channel, key: fx_key, par: fx_param};
  assign wr_vals    = '{start_val: start_value, end_val: end_value};
  assign rd_addr    = AW'(int'(ctl_r) * SLOTS_PER_CONTROL + int'(s_cnt));

  // any valid slot after the current one in this control
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < SLOTS_PER_CONTROL; j++) begin
      if (slot_valid[ctl_r][j] && (j > int'(s_cnt))) begin
        more = 1'b1;
      end
    end
  end

  assign q_hit   = slot_ok_r && slot_valid[ctl_r][slot_r];
  assign clr_hit = slot_valid[ctl_r][s_cnt] && (rd_meta.chan == chan_r);
  assign lerp_go = (state == S_READ);

  mml_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .wr_addr (wr_addr),
    .wr_meta (wr_meta),
    .wr_vals (wr_vals),
    .rd_addr (rd_addr),
    .rd_meta (rd_meta),
    .rd_vals (rd_vals)
  );

  mml_lerp u_lerp (
    .clk     (clk),
    .rst     (rst),
    .go      (lerp_go),
    .vals    (rd_vals),
    .ctl_val (val_r),
    .done    (lerp_done),
    .result  (lerp_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (cmd)
            CMD_SET:   state_next = ctl_ok ? S_SCAN : S_IDLE;
            CMD_CLEAR: state_next = S_CLR_RD;
            CMD_QUERY: state_next = S_QRY;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (slot_valid[ctl_r][s_cnt]) begin
          state_next = S_READ;
        end else if (s_cnt == S_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_READ: state_next = S_LERP;
      S_LERP: begin
        if (lerp_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = last ? S_IDLE : S_SCAN;
        end
      end
      S_CLR_RD: state_next = S_CLR_CK;
      S_CLR_CK: begin
        if ((s_cnt == S_LAST) && (ctl_r == C_LAST)) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_CLR_RD;
        end
      end
      S_QRY: begin
        if (!slot_ok_r || q_hit || (ctl_r == C_LAST)) begin
          state_next = S_OUT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counters and request fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (acc) begin
          ctl_r     <= (cmd == CMD_SET) ? in_ci : '0;
          s_cnt     <= '0;
          slot_r    <= in_si;
          slot_ok_r <= slot_ok;
          chan_r    <= channel;
          val_r     <= control_value;
        end
      end
      S_SCAN: begin
        if (!slot_valid[ctl_r][s_cnt] && (s_cnt != S_LAST)) begin
          s_cnt <= s_cnt + 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready && !last) begin
          s_cnt <= s_cnt + 1'b1;
        end
      end
      S_CLR_CK: begin
        if (s_cnt == S_LAST) begin
          s_cnt <= '0;
          if (ctl_r != C_LAST) begin
            ctl_r <= ctl_r + 1'b1;
          end
        end else begin
          s_cnt <= s_cnt + 1'b1;
        end
      end
      S_QRY: begin
        if (slot_ok_r && !q_hit && (ctl_r != C_LAST)) begin
          ctl_r <= ctl_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    case (state)
      S_READ: begin
        out_channel  <= rd_meta.chan;
        out_fx_key   <= rd_meta.key;
        out_fx_param <= rd_meta.par;
      end
      S_LERP: begin
        fx_value  <= lerp_res;
        mod_state <= '0;
        last      <= !more;
      end
      S_QRY: begin
        out_channel  <= '0;
        out_fx_key   <= '0;
        out_fx_param <= '0;
        fx_value     <= '0;
        mod_state    <= q_hit ? 3'(ctl_r) : NONE;
        last         <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // slot valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CONTROLS; c++) begin
        slot_valid[c] <= '0;
      end
    end else if (we.meta_we) begin
      slot_valid[in_ci][in_si] <= 1'b1;
    end else if (acc && (cmd == CMD_REMOVE) && ctl_ok && slot_ok) begin
      slot_valid[in_ci][in_si] <= 1'b0;
    end else if ((state == S_CLR_CK) && clr_hit) begin
      slot_valid[ctl_r][s_cnt] <= 1'b0;
    end
  end

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the modulation matrix with linear interpolation
// ----------------------------------------------------------------------------
// A short table of directed requests comes first. Results that are plain to
// see (empty table, zero control value, ignored requests, query answers) are
// typed into the table. Every other request is checked against a local copy
// of the routing table. Random requests follow in bursts while the result
// side stalls on its own pattern. One long result stall lets the block back
// up, and one pause lets every result drain.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mml_pkg::*;

  localparam int NCTL   = NUM_CONTROLS_DEF;
  localparam int NSLOT  = SLOTS_PER_CONTROL_DEF;
  localparam int NROUTE = NCTL * NSLOT;

  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [2:0] NO_CONTROL = 3'(NCTL);

  localparam int RAND_ITEMS    = 170;
  localparam int IDLE_LIMIT    = 3000;
  // longer than a full clear sweep, which returns nothing
  localparam int SETTLE_CYCLES = 250;
  localparam int LONG_HOLD     = 300;

  typedef enum int {RX_ALWAYS, RX_HALF, RX_SLOW, RX_MOSTLY} rx_mode_t;

  typedef struct packed {
    logic [3:0]         chan;
    logic [7:0]         key;
    logic [7:0]         par;
    logic signed [15:0] value;
    logic [2:0]         mstate;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [2:0]         ctl;
    logic [3:0]         slot;
    logic [3:0]         chan;
    logic [7:0]         key;
    logic [7:0]         par;
    logic signed [15:0] sv;
    logic signed [15:0] ev;
    logic [15:0]        val;
    logic               fixed;      // expectation typed in the table
    logic               fixed_one;  // one result rather than none
    result_t            fixed_res;
  } request_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         cmd;
  logic [2:0]         control;
  logic [3:0]         slot;
  logic [3:0]         channel;
  logic [7:0]         fx_key;
  logic [7:0]         fx_param;
  logic signed [15:0] start_value;
  logic signed [15:0] end_value;
  logic [15:0]        control_value;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_channel;
  logic [7:0]         out_fx_key;
  logic [7:0]         out_fx_param;
  logic signed [15:0] fx_value;
  logic [2:0]         mod_state;
  logic               last;

  // local copy of the routing table
  bit      route_live [NROUTE];
  meta_t   route_meta [NROUTE];
  vals_t   route_vals [NROUTE];

  result_t  pending_results[$];
  request_t offered;
  int       mismatches;
  int       burst_left;
  bit       long_hold_pending;
  bit       long_hold_done;

  modulation_matrix_lerp_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .control       (control),
    .slot          (slot),
    .channel       (channel),
    .fx_key        (fx_key),
    .fx_param      (fx_param),
    .start_value   (start_value),
    .end_value     (end_value),
    .control_value (control_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .out_fx_key    (out_fx_key),
    .out_fx_param  (out_fx_param),
    .fx_value      (fx_value),
    .mod_state     (mod_state),
    .last          (last)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // start + (end - start) * val, rounded to nearest with ties upward
  function automatic logic signed [15:0] interp_value(input logic signed [15:0] s,
      input logic signed [15:0] e, input logic [15:0] v);
    longint prod;
    longint r;
    prod = (longint'(e) - longint'(s)) * longint'(v);
    r = longint'(s) + ((prod + 32768) >>> 16);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // applies one request to the local table and returns the results it causes
  function automatic void apply_request(input request_t r, output result_t res[$]);
    int      base;
    int      idx;
    result_t one;
    res = {};
    base = int'(r.ctl) * NSLOT;
    idx = base + int'(r.slot);
    one = '0;
    case (r.cmd)
      CMD_SET: begin
        if (r.ctl < NCTL) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (route_live[base + i]) begin
              one.chan  = route_meta[base + i].chan;
              one.key   = route_meta[base + i].key;
              one.par   = route_meta[base + i].par;
              one.value = interp_value(route_vals[base + i].start_val,
                                       route_vals[base + i].end_val, r.val);
              res.push_back(one);
            end
          end
          if (res.size() > 0) res[res.size() - 1].last = 1'b1;
        end
      end
      CMD_ADD: begin
        if (r.ctl < NCTL && r.slot < NSLOT) begin
          route_meta[idx] = '{chan: r.chan, key: r.key, par: r.par};
          route_vals[idx] = '{start_val: r.sv, end_val: r.ev};
          route_live[idx] = 1'b1;
        end
      end
      CMD_UPDATE: begin
        // an empty slot stays empty
        if (r.ctl < NCTL && r.slot < NSLOT && route_live[idx])
          route_vals[idx] = '{start_val: r.sv, end_val: r.ev};
      end
      CMD_REMOVE: begin
        if (r.ctl < NCTL && r.slot < NSLOT) route_live[idx] = 1'b0;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < NROUTE; i++)
          if (route_live[i] && route_meta[i].chan == r.chan) route_live[i] = 1'b0;
      end
      CMD_QUERY: begin
        one.mstate = NO_CONTROL;
        if (r.slot < NSLOT) begin
          for (int c = 0; c < NCTL; c++) begin
            if (route_live[c * NSLOT + int'(r.slot)]) begin
              one.mstate = 3'(c);
              break;
            end
          end
        end
        one.last = 1'b1;
        res.push_back(one);
      end
      default: ;
    endcase
  endfunction

  function automatic void report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function automatic request_t mk_req(input logic [2:0] c, input logic [2:0] ctl,
      input logic [3:0] s, input logic [3:0] ch, input logic [7:0] k, input logic [7:0] p,
      input logic [15:0] sv, input logic [15:0] ev, input logic [15:0] v);
    request_t r;
    r = '0;
    r.cmd = c;
    r.ctl = ctl;
    r.slot = s;
    r.chan = ch;
    r.key = k;
    r.par = p;
    r.sv = sv;
    r.ev = ev;
    r.val = v;
    return r;
  endfunction

  function automatic request_t yields_none(input request_t r);
    r.fixed = 1'b1;
    r.fixed_one = 1'b0;
    return r;
  endfunction

  function automatic request_t yields_one(input request_t r, input logic [3:0] ch,
      input logic [7:0] k, input logic [7:0] p, input logic [15:0] v, input logic [2:0] st);
    r.fixed = 1'b1;
    r.fixed_one = 1'b1;
    r.fixed_res = '{ch, k, p, v, st, 1'b1};
    return r;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    r = mk_req(CMD_SET, 3'($urandom_range(0, NCTL - 1)), 4'($urandom), 4'($urandom),
               8'($urandom), 8'($urandom), pick16(), pick16(), pick16());
    // crowd two controls so that long walks happen
    if ($urandom_range(0, 1)) r.ctl = 3'($urandom_range(0, 1));
    // few channels so that clearing hits something
    if ($urandom_range(0, 1)) r.chan = 4'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.cmd = CMD_SET;
    end else if (pick < 58) begin
      r.cmd = CMD_ADD;
    end else if (pick < 68) begin
      r.cmd = CMD_UPDATE;
    end else if (pick < 76) begin
      r.cmd = CMD_REMOVE;
    end else if (pick < 79) begin
      r.cmd = CMD_CLEAR;
    end else if (pick < 92) begin
      r.cmd = CMD_QUERY;
      r.ctl = 3'($urandom);
    end else begin
      // noise: a control past the table or a spare command code
      r.cmd = 3'($urandom);
      if (r.cmd != CMD_CLEAR && r.cmd != CMD_QUERY && $urandom_range(0, 1))
        r.ctl = 3'($urandom_range(NCTL, 7));
      else
        r.cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
    end
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer(input request_t r);
    offered       <= r;
    cmd           <= r.cmd;
    control       <= r.ctl;
    slot          <= r.slot;
    channel       <= r.chan;
    fx_key        <= r.key;
    fx_param      <= r.par;
    start_value   <= r.sv;
    end_value     <= r.ev;
    control_value <= r.val;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic drain_pause();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result check first, so a result never meets the request of the same edge
  always @(posedge clk) begin
    result_t want;
    result_t fresh[$];
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result ch=%0d key=%0h par=%0h val=%0d st=%0d last=%0b",
                                  out_channel, out_fx_key, out_fx_param, fx_value, mod_state,
                                  last));
      end else begin
        want = pending_results.pop_front();
        if (out_channel !== want.chan || out_fx_key !== want.key ||
            out_fx_param !== want.par || fx_value !== want.value ||
            mod_state !== want.mstate || last !== want.last)
          report_mismatch($sformatf({"expected ch=%0d key=%0h par=%0h val=%0d st=%0d last=%0b,",
                                     " got ch=%0d key=%0h par=%0h val=%0d st=%0d last=%0b"},
                                    want.chan, want.key, want.par, want.value, want.mstate,
                                    want.last, out_channel, out_fx_key, out_fx_param, fx_value,
                                    mod_state, last));
      end
    end
    if (!rst && in_valid && in_ready === 1'b1) begin
      apply_request(offered, fresh);
      if (offered.fixed) begin
        if (offered.fixed_one) pending_results.push_back(offered.fixed_res);
      end else begin
        foreach (fresh[i]) pending_results.push_back(fresh[i]);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: stalls on its own pattern, plus one long hold-off
  initial begin
    rx_mode_t mode;
    int       left;
    out_ready = 1'b0;
    long_hold_done = 1'b0;
    mode = RX_ALWAYS;
    left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_pending && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 80);
        end
        left--;
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
          RX_SLOW:   out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  initial begin
    request_t table_rows[$];
    request_t r;
    int       counted;
    bit       paused;
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = '0;
    control = '0;
    slot = '0;
    channel = '0;
    fx_key = '0;
    fx_param = '0;
    start_value = '0;
    end_value = '0;
    control_value = '0;
    offered = '0;
    mismatches = 0;
    burst_left = 0;
    long_hold_pending = 1'b0;
    counted = 0;
    paused = 1'b0;

    // empty table after reset
    table_rows.push_back(yields_one(mk_req(CMD_QUERY, 0, 0, 0, 0, 0, 0, 0, 0),
                                    0, 0, 0, 0, NO_CONTROL));
    table_rows.push_back(yields_none(mk_req(CMD_SET, 0, 0, 0, 0, 0, 0, 0, 16'h8000)));
    // full-scale span in slot zero
    table_rows.push_back(mk_req(CMD_ADD, 0, 0, 4'hf, 8'hff, 8'hff, 16'h8000, 16'h7fff, 0));
    table_rows.push_back(yields_one(mk_req(CMD_SET, 0, 0, 0, 0, 0, 0, 0, 16'h0000),
                                    4'hf, 8'hff, 8'hff, 16'h8000, '0));
    table_rows.push_back(mk_req(CMD_SET, 0, 0, 0, 0, 0, 0, 0, 16'hffff));
    // falling span in the top slot
    table_rows.push_back(mk_req(CMD_ADD, 0, 4'hf, 0, 0, 0, 16'h7fff, 16'h8000, 0));
    table_rows.push_back(mk_req(CMD_SET, 0, 0, 0, 0, 0, 0, 0, 16'hffff));
    table_rows.push_back(yields_one(mk_req(CMD_QUERY, 3'h7, 4'hf, 0, 0, 0, 0, 0, 0),
                                    0, 0, 0, 0, 3'd0));
    // same slot in two controls, query answers the lower one
    table_rows.push_back(mk_req(CMD_ADD, 5, 7, 5, 8'ha5, 8'h5a, 16'h0100, 16'h0300, 0));
    table_rows.push_back(yields_one(mk_req(CMD_QUERY, 0, 7, 0, 0, 0, 0, 0, 0),
                                    0, 0, 0, 0, 3'd5));
    table_rows.push_back(mk_req(CMD_ADD, 3, 7, 5, 8'h3c, 8'hc3, 16'hfe00, 16'h0200, 0));
    table_rows.push_back(yields_one(mk_req(CMD_QUERY, 0, 7, 0, 0, 0, 0, 0, 0),
                                    0, 0, 0, 0, 3'd3));
    // update of an empty slot leaves it empty
    table_rows.push_back(yields_none(mk_req(CMD_UPDATE, 1, 4, 0, 0, 0, 16'h1234, 16'h4321, 0)));
    table_rows.push_back(yields_none(mk_req(CMD_SET, 1, 0, 0, 0, 0, 0, 0, 16'hffff)));
    table_rows.push_back(mk_req(CMD_UPDATE, 5, 7, 0, 0, 0, 16'hff00, 16'h0100, 0));
    table_rows.push_back(mk_req(CMD_SET, 5, 0, 0, 0, 0, 0, 0, 16'h4000));
    // controls past the table and spare codes do nothing
    table_rows.push_back(yields_none(mk_req(CMD_ADD, 3'h7, 0, 1, 1, 1, 16'h0100, 16'h0100, 0)));
    table_rows.push_back(yields_none(mk_req(CMD_SET, 3'h6, 0, 0, 0, 0, 0, 0, 16'hffff)));
    table_rows.push_back(yields_none(mk_req(CMD_SPARE6, 3'h7, 4'hf, 4'hf, 8'hff, 8'hff,
                                            16'hffff, 16'hffff, 16'hffff)));
    table_rows.push_back(yields_none(mk_req(CMD_SPARE7, 3'h7, 4'hf, 4'hf, 8'hff, 8'hff,
                                            16'hffff, 16'hffff, 16'hffff)));
    // half-way ties of one step either way
    table_rows.push_back(mk_req(CMD_ADD, 2, 1, 9, 8'h11, 8'h22, 16'h0000, 16'h0001, 0));
    table_rows.push_back(mk_req(CMD_ADD, 2, 2, 9, 8'h33, 8'h44, 16'h0000, 16'hffff, 0));
    table_rows.push_back(mk_req(CMD_SET, 2, 0, 0, 0, 0, 0, 0, 16'h8000));
    // clearing a channel drops both copies of slot seven
    table_rows.push_back(yields_none(mk_req(CMD_CLEAR, 0, 0, 5, 0, 0, 0, 0, 0)));
    table_rows.push_back(yields_one(mk_req(CMD_QUERY, 0, 7, 0, 0, 0, 0, 0, 0),
                                    0, 0, 0, 0, NO_CONTROL));
    // removing twice, the second time on an empty slot
    table_rows.push_back(mk_req(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(mk_req(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0));
    table_rows.push_back(yields_one(mk_req(CMD_SET, 0, 0, 0, 0, 0, 0, 0, 16'h0000),
                                    0, 0, 0, 16'h7fff, '0));

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (table_rows[i]) begin
      offer(table_rows[i]);
      idle_gap();
    end

    while (counted < RAND_ITEMS) begin
      r = random_request();
      offer(r);
      if (r.cmd < CMD_SPARE6 && (r.ctl < NCTL || r.cmd == CMD_CLEAR || r.cmd == CMD_QUERY))
        counted++;
      if (counted >= RAND_ITEMS / 2 && !long_hold_pending) begin
        long_hold_pending = 1'b1;
        // keep set-value requests coming while the results back up
        repeat (6) begin
          r = random_request();
          r.cmd = CMD_SET;
          r.ctl = 3'($urandom_range(0, 1));
          offer(r);
        end
        counted += 6;
        idle_gap();
      end else if (counted >= 60 && !paused) begin
        paused = 1'b1;
        drain_pause();
      end else begin
        idle_gap();
      end
    end

    drain_pause();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
